### hdl/step_pulse_sample_generator_assert.svh
// assertion macros shared by the queue, back end and top-level rtl files
// clocked on clk_i, the plain form is disabled while rst_ni is low
`ifndef STEP_PULSE_SAMPLE_GENERATOR_ASSERT_SVH
`define STEP_PULSE_SAMPLE_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define SPSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SPSG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SPSG_ASSERT(lbl, prop, msg)
`define SPSG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hdl/spsg_pkg.sv
package spsg_pkg;

  // request codes on the input channel
  localparam logic [2:0] REQ_PORT_BIT   = 3'd0;
  localparam logic [2:0] REQ_START_STEP = 3'd1;
  localparam logic [2:0] REQ_STEP_BIT   = 3'd2;
  localparam logic [2:0] REQ_PERIOD     = 3'd3;
  localparam logic [2:0] REQ_FRAME      = 3'd4;

  // configuration register indexes
  localparam logic CFG_PULSE_FRAMES = 1'b0;
  localparam logic CFG_TICK_DIVISOR = 1'b1;

  localparam logic [9:0]  RESET_PULSE_FRAMES  = 10'd2;
  localparam logic [15:0] RESET_TICK_DIVISOR  = 16'd1;
  localparam logic [31:0] RESET_PERIOD_FRAMES = 32'd40;

  typedef enum logic [2:0] {
    OP_PORT_BIT,
    OP_START_STEP,
    OP_STEP_BIT,
    OP_PERIOD,
    OP_FRAME
  } op_e;

  // classified request as it travels through the queue
  typedef struct packed {
    op_e         op;
    logic [4:0]  pin;
    logic        level;
    logic [31:0] ticks;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  function automatic logic [31:0] write_bit(logic [31:0] word, logic [4:0] pin,
                                            logic level);
    logic [31:0] res;
    res      = word;
    res[pin] = level;
    return res;
  endfunction

endpackage

### hdl/spsg_front.sv
module spsg_front import spsg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [4:0]  pin_i,
  input  logic        level_i,
  input  logic [31:0] ticks_i,
  input  logic        full_i,
  output logic        push_o,
  output item_t       item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  keep;
  logic  accept;

  // map request codes, drop unused codes and zero periods
  always_comb begin
    keep   = 1'b1;
    item_d = '{op: OP_FRAME, pin: pin_i, level: level_i, ticks: ticks_i};
    unique case (req_type_i)
      REQ_PORT_BIT:   item_d.op = OP_PORT_BIT;
      REQ_START_STEP: item_d.op = OP_START_STEP;
      REQ_STEP_BIT:   item_d.op = OP_STEP_BIT;
      REQ_PERIOD: begin
        item_d.op = OP_PERIOD;
        keep      = (ticks_i != '0);
      end
      REQ_FRAME:      item_d.op = OP_FRAME;
      default:        keep = 1'b0;
    endcase
  end

  assign push_o     = valid_q && !full_i;
  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = keep;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

### hdl/spsg_queue.sv
`include "step_pulse_sample_generator_assert.svh"

module spsg_queue import spsg_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `SPSG_ASSERT(a_count_bound, count_q <= FullCnt, "queue count above depth")
  `SPSG_ASSERT(a_no_pop_empty, pop_i |-> count_q != '0, "pop from empty queue")
  `SPSG_ASSERT(a_no_push_full, push_i |-> count_q != FullCnt, "push into full queue")

endmodule

### hdl/spsg_div.sv
module spsg_div import spsg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  // restoring divider, one quotient bit per cycle
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] dvs_q, dvs_d;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem_q, quo_q[31]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
      quo_d = {quo_q[30:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o = '{busy: busy_q, done: done_q, quotient: quo_q};

endmodule

### hdl/spsg_back.sv
`include "step_pulse_sample_generator_assert.svh"

module spsg_back import spsg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [9:0]  pulse_frames_i,
  input  logic [15:0] tick_divisor_i,
  input  logic        empty_i,
  input  item_t       item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] sample_o,
  output logic        segment_request_o
);

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_DIV = 1'b1;

  logic        st_q, st_d;
  logic [31:0] port_word_q, port_word_d;
  logic [31:0] staged_word_q, staged_word_d;
  logic        staged_valid_q, staged_valid_d;
  logic [31:0] active_word_q, active_word_d;
  logic [9:0]  pulse_left_q, pulse_left_d;
  logic [31:0] delay_left_q, delay_left_d;
  logic [31:0] period_q, period_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] sample_q, sample_d;
  logic        seg_q, seg_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        load;
  logic [31:0] next_word;
  logic        pulse_on;
  logic [31:0] pulse_ext;
  logic [31:0] delay_sat;
  logic [31:0] delay_plain;

  spsg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign pop_o = (st_q == ST_RUN) && !empty_i && (!out_valid_q || !out_stall_i);

  // segment load terms, both delay variants built in parallel
  assign load        = (pulse_left_q == '0) && (delay_left_q == '0);
  assign next_word   = staged_valid_q ? staged_word_q : port_word_q;
  assign pulse_on    = (next_word != port_word_q) && (pulse_frames_i != '0);
  assign pulse_ext   = {22'b0, pulse_frames_i};
  assign delay_sat   = (period_q > pulse_ext) ? period_q - pulse_ext : '0;
  assign delay_plain = (period_q != '0) ? period_q - 32'd1 : '0;

  always_comb begin
    st_d           = st_q;
    port_word_d    = port_word_q;
    staged_word_d  = staged_word_q;
    staged_valid_d = staged_valid_q;
    active_word_d  = active_word_q;
    pulse_left_d   = pulse_left_q;
    delay_left_d   = delay_left_q;
    period_d       = period_q;
    out_valid_d    = out_valid_q && out_stall_i;
    sample_d       = sample_q;
    seg_d          = seg_q;
    div_req        = '{start: 1'b0, dividend: item_i.ticks,
                       divisor: (tick_divisor_i == '0) ? 16'd1 : tick_divisor_i};

    if (st_q == ST_DIV && div_rsp.done) begin
      period_d = div_rsp.quotient;
      st_d     = ST_RUN;
    end

    if (pop_o) begin
      unique case (item_i.op)
        OP_PORT_BIT: port_word_d = write_bit(port_word_q, item_i.pin, item_i.level);
        OP_START_STEP: begin
          staged_word_d  = port_word_q;
          staged_valid_d = 1'b1;
        end
        OP_STEP_BIT: begin
          staged_word_d  = write_bit(next_word, item_i.pin, item_i.level);
          staged_valid_d = 1'b1;
        end
        OP_PERIOD: begin
          div_req.start = 1'b1;
          st_d          = ST_DIV;
        end
        OP_FRAME: begin
          out_valid_d = 1'b1;
          seg_d       = load;
          if (load) begin
            staged_valid_d = 1'b0;
            active_word_d  = next_word;
            if (pulse_on) begin
              sample_d     = next_word;
              pulse_left_d = pulse_frames_i - 10'd1;
              delay_left_d = delay_sat;
            end else begin
              sample_d     = port_word_q;
              pulse_left_d = '0;
              delay_left_d = delay_plain;
            end
          end else if (pulse_left_q != '0) begin
            sample_d     = active_word_q;
            pulse_left_d = pulse_left_q - 10'd1;
          end else begin
            sample_d     = port_word_q;
            delay_left_d = delay_left_q - 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q           <= ST_RUN;
      port_word_q    <= '0;
      staged_word_q  <= '0;
      staged_valid_q <= 1'b0;
      active_word_q  <= '0;
      pulse_left_q   <= '0;
      delay_left_q   <= '0;
      period_q       <= RESET_PERIOD_FRAMES;
      out_valid_q    <= 1'b0;
    end else begin
      st_q           <= st_d;
      port_word_q    <= port_word_d;
      staged_word_q  <= staged_word_d;
      staged_valid_q <= staged_valid_d;
      active_word_q  <= active_word_d;
      pulse_left_q   <= pulse_left_d;
      delay_left_q   <= delay_left_d;
      period_q       <= period_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    seg_q    <= seg_d;
  end

  assign out_valid_o       = out_valid_q;
  assign sample_o          = sample_q;
  assign segment_request_o = seg_q;

  `SPSG_ASSERT(a_frame_out, pop_o && item_i.op == OP_FRAME |=> out_valid_q,
               "frame transfer gave no result")
  `SPSG_ASSERT(a_div_running, st_q == ST_DIV |-> div_rsp.busy || div_rsp.done,
               "waiting on an idle divider")
  `SPSG_ASSERT(a_div_start, div_req.start |-> !div_rsp.busy,
               "divider restarted while busy")

endmodule

### hdl/step_pulse_sample_generator.sv
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------------------
// in        | in_valid_i / in_stall_o   | req_type_i, pin_i, level_i, ticks_i
// out       | out_valid_o / out_stall_i | sample_o, segment_request_o
// cfg       | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// a transfer passes the front register and the request queue, then the back end
// takes it; a frame tick result is in the output register the cycle after the
// back end takes it
// a period request holds the back end until the 32-step restoring divider is
// done; the front and the queue keep taking transfers until the queue is full
// reset clears port, staged and pulse state, period 40, pulse length 2, divisor 1
// a stalled result holds the back end, the queue then fills and stalls the input

`include "step_pulse_sample_generator_assert.svh"

module step_pulse_sample_generator import spsg_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [4:0]  pin_i,
  input  logic        level_i,
  input  logic [31:0] ticks_i,
  // sample channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] sample_o,
  output logic        segment_request_o,
  // register writes
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [9:0]  pulse_frames_q;
  logic [15:0] tick_divisor_q;

  // front to queue
  logic  push;
  logic  full;
  item_t front_item;

  // queue to back end
  logic  pop;
  logic  empty;
  item_t queue_item;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_frames_q <= RESET_PULSE_FRAMES;
      tick_divisor_q <= RESET_TICK_DIVISOR;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PULSE_FRAMES: pulse_frames_q <= cfg_data_i[9:0];
        CFG_TICK_DIVISOR: tick_divisor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // classifies requests, drops unused codes and zero periods
  spsg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .pin_i      (pin_i),
    .level_i    (level_i),
    .ticks_i    (ticks_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (front_item)
  );

  // decouples the front from the back end
  spsg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (queue_item)
  );

  // port and step words, pulse and delay counters, period divider, output register
  spsg_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pulse_frames_i    (pulse_frames_q),
    .tick_divisor_i    (tick_divisor_q),
    .empty_i           (empty),
    .item_i            (queue_item),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sample_o          (sample_o),
    .segment_request_o (segment_request_o)
  );

  `SPSG_ASSERT(a_push_when_room, push |-> !full, "front pushed into a full queue")
  `SPSG_ASSERT(a_stall_needs_full, in_stall_o |-> full, "input stalled with queue room")
  `SPSG_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result during reset")

endmodule
